// ----- hdl/qfd_pkg.sv -----
// Shared widths, constants and types of the quadrature FM demodulator.
`timescale 1ns / 1ps
`default_nettype none
package qfd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MUL_W         = 2 * SAMPLE_BITS;
    localparam int PROD_W        = MUL_W + 1;
    // three bits of headroom for the CORDIC gain and the pre-rotation negation
    localparam int XY_W          = PROD_W + 3;
    localparam int ACC_W         = 26;
    localparam int CORDIC_STEPS  = 21;
    localparam int PHASE_W       = 16;
    localparam int GAIN_W        = 16;
    localparam int SCALED_W      = PHASE_W + GAIN_W + 1;
    localparam int OUT_W         = 16;
    localparam int PHASE_LSB     = 8;
    localparam int GAIN_FRAC     = 12;

    localparam logic [GAIN_W-1:0]       GAIN_RESET = GAIN_W'(10430);
    localparam logic signed [ACC_W-1:0] ANGLE_PI   = ACC_W'(8388608);

    // control bits that travel alongside each item
    typedef struct packed {
        logic valid;
        logic sob;
        logic zero;
    } ctl_t;

    // arctan(2^-k) with pi = 2^23
    function automatic logic signed [ACC_W-1:0] atan_at(input int k);
        logic signed [ACC_W-1:0] r;
        unique case (k)
            0:       r = ACC_W'(2097152);
            1:       r = ACC_W'(1238021);
            2:       r = ACC_W'(654136);
            3:       r = ACC_W'(332050);
            4:       r = ACC_W'(166669);
            5:       r = ACC_W'(83416);
            6:       r = ACC_W'(41718);
            7:       r = ACC_W'(20860);
            8:       r = ACC_W'(10430);
            9:       r = ACC_W'(5215);
            10:      r = ACC_W'(2608);
            11:      r = ACC_W'(1304);
            12:      r = ACC_W'(652);
            13:      r = ACC_W'(326);
            14:      r = ACC_W'(163);
            15:      r = ACC_W'(81);
            16:      r = ACC_W'(41);
            17:      r = ACC_W'(20);
            18:      r = ACC_W'(10);
            19:      r = ACC_W'(5);
            20:      r = ACC_W'(3);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/qfd_cmul.sv -----
// Conjugate product of current and previous sample, plus CORDIC pre-rotation.
`timescale 1ns / 1ps
`default_nettype none
module qfd_cmul
    import qfd_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_q,
    input  wire logic                          start_of_burst,
    output ctl_t                               ctl,
    output logic signed [XY_W-1:0]             x,
    output logic signed [XY_W-1:0]             y,
    output logic signed [ACC_W-1:0]            acc
);

    logic signed [SAMPLE_BITS-1:0] prev_i_reg, prev_q_reg;
    logic signed [MUL_W-1:0]       pii_reg, pqq_reg, pqi_reg, piq_reg;
    logic signed [PROD_W-1:0]      re_reg, im_reg;
    ctl_t                          c1_reg, c2_reg, c3_reg;
    ctl_t                          c1_next;
    logic signed [XY_W-1:0]        x_reg, y_reg, x_next, y_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;

    always_comb
    begin
        c1_next.valid = in_valid;
        c1_next.sob   = start_of_burst;
        c1_next.zero  = 1'b0;
    end

    // previous sample moves on every accepted item, burst start included
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_i_reg <= '0;
            prev_q_reg <= '0;
        end
        else if (en && in_valid)
        begin
            prev_i_reg <= sample_i;
            prev_q_reg <= sample_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else if (en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
            c3_reg <= {c2_reg.valid, c2_reg.sob, (re_reg == '0) && (im_reg == '0)};
        end
    end

    always_comb
    begin
        if (re_reg < 0)
        begin
            x_next   = -XY_W'(re_reg);
            y_next   = -XY_W'(im_reg);
            acc_next = (im_reg >= 0) ? ANGLE_PI : -ANGLE_PI;
        end
        else
        begin
            x_next   = XY_W'(re_reg);
            y_next   = XY_W'(im_reg);
            acc_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pii_reg <= sample_i * prev_i_reg;
            pqq_reg <= sample_q * prev_q_reg;
            pqi_reg <= sample_q * prev_i_reg;
            piq_reg <= sample_i * prev_q_reg;
            re_reg  <= PROD_W'(pii_reg) + PROD_W'(pqq_reg);
            im_reg  <= PROD_W'(pqi_reg) - PROD_W'(piq_reg);
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
        end
    end

    assign ctl = c3_reg;
    assign x   = x_reg;
    assign y   = y_reg;
    assign acc = acc_reg;

endmodule
`default_nettype wire

// ----- hdl/qfd_cordic.sv -----
// Vectoring CORDIC, one micro-rotation per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none
module qfd_cordic
    import qfd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire ctl_t                    ctl_in,
    input  wire logic signed [XY_W-1:0]  x_in,
    input  wire logic signed [XY_W-1:0]  y_in,
    input  wire logic signed [ACC_W-1:0] acc_in,
    output ctl_t                         ctl_out,
    output logic signed [ACC_W-1:0]      acc_out
);

    ctl_t                    c_reg   [CORDIC_STEPS];
    logic signed [XY_W-1:0]  x_reg   [CORDIC_STEPS];
    logic signed [XY_W-1:0]  y_reg   [CORDIC_STEPS];
    logic signed [ACC_W-1:0] acc_reg [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        ctl_t                    c_cur;
        logic signed [XY_W-1:0]  x_cur, y_cur, x_next, y_next;
        logic signed [ACC_W-1:0] acc_cur, acc_next;

        if (k == 0)
        begin : g_first
            assign c_cur   = ctl_in;
            assign x_cur   = x_in;
            assign y_cur   = y_in;
            assign acc_cur = acc_in;
        end
        else
        begin : g_rest
            assign c_cur   = c_reg[k-1];
            assign x_cur   = x_reg[k-1];
            assign y_cur   = y_reg[k-1];
            assign acc_cur = acc_reg[k-1];
        end

        // arithmetic shifts round toward minus infinity
        always_comb
        begin
            if (y_cur > 0)
            begin
                x_next   = x_cur + (y_cur >>> k);
                y_next   = y_cur - (x_cur >>> k);
                acc_next = acc_cur + atan_at(k);
            end
            else
            begin
                x_next   = x_cur - (y_cur >>> k);
                y_next   = y_cur + (x_cur >>> k);
                acc_next = acc_cur - atan_at(k);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c_reg[k] <= '0;
            else if (en)
                c_reg[k] <= c_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]   <= x_next;
                y_reg[k]   <= y_next;
                acc_reg[k] <= acc_next;
            end
        end
    end

    assign ctl_out = c_reg[CORDIC_STEPS-1];
    assign acc_out = acc_reg[CORDIC_STEPS-1];

endmodule
`default_nettype wire

// ----- hdl/qfd_scale.sv -----
// Phase rounding, gain multiply, rounding and saturation, output register.
`timescale 1ns / 1ps
`default_nettype none
module qfd_scale
    import qfd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire ctl_t                    ctl_in,
    input  wire logic signed [ACC_W-1:0] acc_in,
    input  wire logic [GAIN_W-1:0]       gain,
    output logic                         out_valid,
    output logic signed [OUT_W-1:0]      demod_value,
    output logic                         result_valid
);

    localparam int RND_W = SCALED_W + 1;
    localparam int VAL_W = RND_W - GAIN_FRAC;

    localparam logic signed [VAL_W-1:0] SAT_MAX = VAL_W'(32767);
    localparam logic signed [VAL_W-1:0] SAT_MIN = -VAL_W'(32768);

    ctl_t                       ca_reg, cb_reg, cc_reg;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [PHASE_W-1:0]  phase_reg, phase_next;
    logic signed [SCALED_W-1:0] prod_reg;
    logic signed [RND_W-1:0]    prod_rnd;
    logic signed [VAL_W-1:0]    val;
    logic signed [OUT_W-1:0]    value_reg, value_next;

    always_comb
    begin
        acc_rnd = acc_in + ACC_W'(128);
        // phase wraps to 16 bits, so pi lands on -32768
        if (ctl_in.zero)
            phase_next = '0;
        else
            phase_next = acc_rnd[PHASE_LSB +: PHASE_W];
    end

    always_comb
    begin
        prod_rnd = RND_W'(prod_reg) + RND_W'(2048);
        val      = VAL_W'(prod_rnd >>> GAIN_FRAC);
        priority if (cb_reg.sob)
            value_next = '0;
        else if (val > SAT_MAX)
            value_next = OUT_W'(SAT_MAX);
        else if (val < SAT_MIN)
            value_next = OUT_W'(SAT_MIN);
        else
            value_next = OUT_W'(val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= '0;
            cb_reg <= '0;
            cc_reg <= '0;
        end
        else if (en)
        begin
            ca_reg <= ctl_in;
            cb_reg <= ca_reg;
            cc_reg <= cb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phase_reg <= phase_next;
            prod_reg  <= SCALED_W'(phase_reg) * $signed({1'b0, gain});
            value_reg <= value_next;
        end
    end

    assign out_valid    = cc_reg.valid;
    assign result_valid = !cc_reg.sob;
    assign demod_value  = value_reg;

endmodule
`default_nettype wire

// ----- hdl/quadrature_fm_demodulator.sv -----
// Top level of the quadrature FM demodulator.
// Input channel: in_valid/in_ready with sample_i, sample_q, start_of_burst.
// Output channel: out_valid/out_ready with demod_value, result_valid.
// Every accepted item yields exactly one result item, in order.
// Each sample is multiplied by the conjugate of the one before it; the
// angle of that product comes from a 21-stage vectoring CORDIC
// (pi = 32768 after rounding) and is scaled by demod_gain (unsigned Q4.12)
// with rounding and saturation to signed 16 bits.
// A start_of_burst item only loads the stored sample; its result has
// result_valid = 0 and demod_value = 0.
// Throughput: one item per cycle while no result waits at the output.
// The pipeline is 27 register stages deep: 3 for products, sums and
// pre-rotation, 21 CORDIC micro-rotations, 3 for phase rounding, gain
// multiply and the output register. Stall: the whole pipeline advances
// together whenever the output register is empty or being taken; in_ready
// drops only while a result waits. Reset: pipeline emptied, stored sample
// cleared to zero, gain set to 10430. demod_gain is written through
// demod_gain_we/demod_gain_wdata by the user only while idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_fm_demodulator
    import qfd_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          demod_gain_we,
    input  wire logic [GAIN_W-1:0]             demod_gain_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_q,
    input  wire logic                          start_of_burst,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [OUT_W-1:0]            demod_value,
    output logic                               result_valid
);

    logic                    en;
    logic [GAIN_W-1:0]       gain_reg;
    ctl_t                    cm_ctl, co_ctl;
    logic signed [XY_W-1:0]  cm_x, cm_y;
    logic signed [ACC_W-1:0] cm_acc, co_acc;

    // one enable for all stages: advance unless a result is stuck at the port
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RESET;
        else if (demod_gain_we)
            gain_reg <= demod_gain_wdata;
    end

    qfd_cmul u_cmul (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .sample_i       (sample_i),
        .sample_q       (sample_q),
        .start_of_burst (start_of_burst),
        .ctl            (cm_ctl),
        .x              (cm_x),
        .y              (cm_y),
        .acc            (cm_acc)
    );

    qfd_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (cm_ctl),
        .x_in    (cm_x),
        .y_in    (cm_y),
        .acc_in  (cm_acc),
        .ctl_out (co_ctl),
        .acc_out (co_acc)
    );

    qfd_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .ctl_in       (co_ctl),
        .acc_in       (co_acc),
        .gain         (gain_reg),
        .out_valid    (out_valid),
        .demod_value  (demod_value),
        .result_valid (result_valid)
    );

endmodule
`default_nettype wire
